// ===== design/dcrp_pkg.sv =====
`default_nettype none

package dcrp_pkg;

    // Client phases, encoded as reported on client_state
    typedef enum logic [1:0] {
        PH_INIT       = 2'd0,
        PH_SELECTING  = 2'd1,
        PH_REQUESTING = 2'd2,
        PH_BOUND      = 2'd3
    } phase_t;

    // Parser modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_HEADER = 3'd1,
        MODE_CODE   = 3'd2,
        MODE_LEN    = 3'd3,
        MODE_TYPE   = 3'd4,
        MODE_SERVER = 3'd5,
        MODE_SKIP   = 3'd6
    } mode_t;

    localparam logic [31:0] XID_RESET   = 32'hfadebeef;

    // Header byte positions
    localparam logic [7:0] POS_XID_LAST    = 8'd7;
    localparam logic [7:0] POS_YIADDR_LAST = 8'd19;
    localparam logic [7:0] POS_COOKIE_0    = 8'd236;
    localparam logic [7:0] POS_COOKIE_1    = 8'd237;
    localparam logic [7:0] POS_COOKIE_2    = 8'd238;
    localparam logic [7:0] POS_COOKIE_3    = 8'd239;

    // Magic cookie bytes
    localparam logic [7:0] COOKIE_0 = 8'd99;
    localparam logic [7:0] COOKIE_1 = 8'd130;
    localparam logic [7:0] COOKIE_2 = 8'd83;
    localparam logic [7:0] COOKIE_3 = 8'd99;

    // Option codes and message kinds
    localparam logic [7:0] OPT_PAD    = 8'd0;
    localparam logic [7:0] OPT_TYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER = 8'd54;
    localparam logic [7:0] OPT_END    = 8'hff;
    localparam logic [7:0] KIND_OFFER = 8'd2;
    localparam logic [7:0] KIND_ACK   = 8'd5;

    localparam logic [1:0] SERVER_LAST = 2'd3;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  pos;
        mode_t       mode;
        logic [31:0] word_shift;
        logic [31:0] your_addr;
        logic [31:0] offered;
        logic [31:0] server;
        logic [31:0] committed;
        logic [7:0]  opt_code;
        logic [7:0]  opt_rem;
        logic [7:0]  kind;
    } dcrp_state_t;

    typedef struct packed {
        logic action;
        logic [7:0] data_byte;
        logic first_byte;
    } dcrp_item_t;

    typedef struct packed {
        logic reply_request;
        logic bound_event;
        logic packet_dropped;
    } dcrp_flags_t;

    localparam dcrp_state_t STATE_RESET = '{
        phase:      PH_INIT,
        pos:        8'd0,
        mode:       MODE_IDLE,
        word_shift: 32'd0,
        your_addr:  32'd0,
        offered:    32'd0,
        server:     32'd0,
        committed:  32'd0,
        opt_code:   8'd0,
        opt_rem:    8'd0,
        kind:       8'd0
    };

    // Expected cookie byte at a header position; 1 in ok when it matches or the position holds no cookie byte
    function automatic logic cookie_ok(input logic [7:0] pos, input logic [7:0] b);
        logic ok;
        begin
            ok = 1'b1;
            if (pos == POS_COOKIE_0) ok = (b == COOKIE_0);
            if (pos == POS_COOKIE_1) ok = (b == COOKIE_1);
            if (pos == POS_COOKIE_2) ok = (b == COOKIE_2);
            if (pos == POS_COOKIE_3) ok = (b == COOKIE_3);
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/dcrp_step.sv =====
`default_nettype none

module dcrp_step (
    input  wire dcrp_pkg::dcrp_state_t cur,
    input  wire dcrp_pkg::dcrp_item_t  item,
    input  wire logic [31:0]           xid,
    output dcrp_pkg::dcrp_state_t      nxt,
    output dcrp_pkg::dcrp_flags_t      flags
);
    import dcrp_pkg::*;

    logic [7:0]  b;
    logic [31:0] shifted;
    mode_t       mode_v;
    logic [7:0]  rest;

    assign b       = item.data_byte;
    assign shifted = {cur.word_shift[23:0], b};

    // Compute the state after one item and its event flags
    always_comb
    begin
        nxt    = cur;
        flags  = '0;
        mode_v = cur.mode;
        rest   = 8'd0;
        if (item.action)
        begin
            nxt.phase = PH_SELECTING;
            nxt.mode  = MODE_IDLE;
        end
        else
        begin
            // start of a datagram
            if (item.first_byte)
            begin
                if (cur.phase == PH_SELECTING || cur.phase == PH_REQUESTING)
                begin
                    mode_v   = MODE_HEADER;
                    nxt.pos  = 8'd0;
                    nxt.kind = 8'd0;
                end
                else
                begin
                    mode_v = MODE_IDLE;
                end
            end
            nxt.mode = mode_v;

            unique case (mode_v)
                MODE_IDLE:
                begin
                end
                MODE_HEADER:
                begin
                    nxt.word_shift = shifted;
                    if ((nxt.pos == POS_XID_LAST && shifted != xid) ||
                        !cookie_ok(nxt.pos, b))
                    begin
                        flags.packet_dropped = 1'b1;
                        nxt.mode = MODE_IDLE;
                    end
                    else
                    begin
                        if (nxt.pos == POS_YIADDR_LAST)
                            nxt.your_addr = shifted;
                        if (nxt.pos == POS_COOKIE_3)
                            nxt.mode = MODE_CODE;
                        else
                            nxt.pos = nxt.pos + 8'd1;
                    end
                end
                MODE_CODE:
                begin
                    if (b == OPT_END)
                    begin
                        if (cur.kind == KIND_OFFER)
                        begin
                            nxt.phase = PH_REQUESTING;
                            flags.reply_request = 1'b1;
                        end
                        else if (cur.kind == KIND_ACK)
                        begin
                            nxt.committed = cur.offered;
                            nxt.phase = PH_BOUND;
                            flags.bound_event = 1'b1;
                        end
                        nxt.mode = MODE_IDLE;
                    end
                    else if (b != OPT_PAD)
                    begin
                        nxt.opt_code = b;
                        nxt.mode = MODE_LEN;
                    end
                end
                MODE_LEN:
                begin
                    nxt.opt_rem = b;
                    if (cur.opt_code == OPT_TYPE)
                        nxt.mode = MODE_TYPE;
                    else if (cur.opt_code == OPT_SERVER)
                    begin
                        nxt.pos = 8'd0;
                        nxt.mode = MODE_SERVER;
                    end
                    else
                        nxt.mode = (b != 8'd0) ? MODE_SKIP : MODE_CODE;
                end
                MODE_TYPE:
                begin
                    nxt.kind = b;
                    if ((b == KIND_OFFER && cur.phase == PH_SELECTING) ||
                        (b == KIND_ACK && cur.phase == PH_REQUESTING))
                    begin
                        if (b == KIND_OFFER)
                            nxt.offered = cur.your_addr;
                        rest = (cur.opt_rem != 8'd0) ? cur.opt_rem - 8'd1 : 8'd0;
                        nxt.opt_rem = rest;
                        nxt.mode = (rest != 8'd0) ? MODE_SKIP : MODE_CODE;
                    end
                    else
                    begin
                        flags.packet_dropped = 1'b1;
                        nxt.mode = MODE_IDLE;
                    end
                end
                MODE_SERVER:
                begin
                    nxt.word_shift = shifted;
                    if (cur.pos[1:0] == SERVER_LAST && cur.pos[7:2] == 6'd0)
                    begin
                        nxt.server = shifted;
                        rest = (cur.opt_rem >= 8'd4) ? cur.opt_rem - 8'd4 : 8'd0;
                        nxt.opt_rem = rest;
                        nxt.mode = (rest != 8'd0) ? MODE_SKIP : MODE_CODE;
                    end
                    else
                    begin
                        nxt.pos = {6'd0, cur.pos[1:0] + 2'd1};
                    end
                end
                MODE_SKIP:
                begin
                    nxt.opt_rem = cur.opt_rem - 8'd1;
                    if (cur.opt_rem == 8'd1)
                        nxt.mode = MODE_CODE;
                end
                default:
                begin
                    nxt.mode = MODE_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/dhcp_client_reply_parser.sv =====
// DHCP client reply parser.
// Input channel (in_valid/in_ready) carries one item per transfer: either a
// "discover sent" event (action = 1) or one received reply byte (data_byte)
// with first_byte marking the start of a datagram. Output channel
// (out_valid/out_ready) returns exactly one result per item: client phase,
// offered, server and committed addresses, and the event flags
// reply_request, bound_event and packet_dropped.
// Throughput: one item per cycle while out_ready is high. An accepted item
// lands in an input register; once the output register can take it, it is
// parsed against the client state and the result is written to the output
// register.
// Stall: while out_ready is low the result holds; the input register still
// takes one more item, after which in_ready drops until the output drains.
// Reset (rst_n low, asynchronous): client in init, parser idle, all
// addresses zero, transaction id 0xfadebeef. cfg_write_en loads a new
// transaction id from cfg_write_data; write it only while no item is in
// flight.
`default_nettype none

module dhcp_client_reply_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [31:0] cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       client_state,
    output logic [31:0]      offered_address,
    output logic [31:0]      server_address,
    output logic [31:0]      committed_ip,
    output logic             reply_request,
    output logic             bound_event,
    output logic             packet_dropped
);
    import dcrp_pkg::*;

    logic [31:0] xid_reg;
    logic        in_vld_reg;
    dcrp_item_t  item_reg;
    dcrp_state_t state_reg;
    dcrp_state_t state_next;
    dcrp_flags_t step_flags;
    logic        out_vld_reg;
    logic [1:0]  phase_reg;
    logic [31:0] offered_reg;
    logic [31:0] server_reg;
    logic [31:0] committed_reg;
    dcrp_flags_t flags_reg;
    logic        advance;

    // Parse when an item is held and the result register can take it
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    // Hold the transaction id
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xid_reg <= XID_RESET;
        else if (cfg_write_en)
            xid_reg <= cfg_write_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_ready)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= '{action: action, data_byte: data_byte, first_byte: first_byte};
    end

    dcrp_step u_step (
        .cur   (state_reg),
        .item  (item_reg),
        .xid   (xid_reg),
        .nxt   (state_next),
        .flags (step_flags)
    );

    // Advance the client and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= 1'b1;
        else if (out_ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            phase_reg     <= state_next.phase;
            offered_reg   <= state_next.offered;
            server_reg    <= state_next.server;
            committed_reg <= state_next.committed;
            flags_reg     <= step_flags;
        end
    end

    assign out_valid       = out_vld_reg;
    assign client_state    = phase_reg;
    assign offered_address = offered_reg;
    assign server_address  = server_reg;
    assign committed_ip    = committed_reg;
    assign reply_request   = flags_reg.reply_request;
    assign bound_event     = flags_reg.bound_event;
    assign packet_dropped  = flags_reg.packet_dropped;

    // An offer completion always leaves the client requesting
    a_reply_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reply_request) |-> (client_state == PH_REQUESTING))
        else $error("reply_request without requesting phase");

    // An acknowledgement commits the offered address and binds
    a_bound_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bound_event) |->
            (client_state == PH_BOUND && committed_ip == offered_address))
        else $error("bound_event without commit");

    // The committed address changes only on an acknowledgement
    a_commit_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !step_flags.bound_event) |=> $stable(state_reg.committed))
        else $error("committed address changed without bound_event");

    // A held item that cannot advance blocks the input
    a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |-> !in_ready)
        else $error("input taken while held item is stalled");

endmodule

`default_nettype wire
